[rtl/core/median_of_set_core_macros.svh]
// ----------------------------------------------------------------------------
// Median of set: assertion macros
// Shared concurrent assertion forms, removed when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_OF_SET_CORE_MACROS_SVH
`define MEDIAN_OF_SET_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("median_of_set: assertion failed");
`define MOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("median_of_set: assertion failed");
`else
`define MOS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/mos_pkg.sv]
// ----------------------------------------------------------------------------
// Median of set: package
// Widths, sizes and shared types of the sorting chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mos_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int MAX_ITEMS = 64;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef struct packed {
    logic    ins_en;
    logic    shift_en;
    sample_t sample;
  } mos_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/mos_if.sv]
// ----------------------------------------------------------------------------
// Median of set: channel interfaces
// Valid/ready channels for input samples and median results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mos_in_if import mos_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    has_sample;
  logic    last;

  modport source (output valid, sample, has_sample, last, input ready);
  modport sink (input valid, sample, has_sample, last, output ready);
endinterface

interface mos_out_if import mos_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median;
  logic    empty_set;
  logic    overflowed;
  cnt_t    sample_count;

  modport source (output valid, median, empty_set, overflowed, sample_count, input ready);
  modport sink (input valid, median, empty_set, overflowed, sample_count, output ready);
endinterface

`default_nettype wire

[rtl/core/mos_cell.sv]
// ----------------------------------------------------------------------------
// Median of set: sorter cell
// One entry of the insertion chain; takes the broadcast sample, its left
// neighbor's entry when shifting up, or its right neighbor's when reading out.
// ----------------------------------------------------------------------------
`default_nettype none

module mos_cell import mos_pkg::*; (
  input  wire            clk,
  input  wire mos_ctrl_t ctrl,
  input  wire            occ,
  input  wire            left_ins,
  input  wire sample_t   left_val,
  input  wire sample_t   right_val,
  output logic           ins,
  output sample_t        val
);

  sample_t val_r;
  sample_t val_nxt;

  assign ins = !occ || (val_r > ctrl.sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift_en) begin
      val_nxt = right_val;
    end else if (ctrl.ins_en) begin
      if (left_ins) begin
        val_nxt = left_val;
      end else if (ins) begin
        val_nxt = ctrl.sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/median_of_set_core.sv]
// ----------------------------------------------------------------------------
// Median of set: top level
// Insertion-sorting chain of cells with a shift-down readout of the median.
// ----------------------------------------------------------------------------
// Throughput: one sample word per cycle while a set is filling.
// After the closing word of a set is accepted, the chain shifts down once per
// cycle until the middle entries reach the first two cells (an empty set needs
// no shift); the result word is then loaded into the output register once that
// register is free, and is presented from there.
// The next set is accepted as soon as the result enters the output register.
// Reset (synchronous, active low) empties the set; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "median_of_set_core_macros.svh"

module median_of_set_core import mos_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  mos_in_if.sink      in_if,
  mos_out_if.source   out_if
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_SHIFT = 1'b1;

  logic state_r, state_nxt;
  cnt_t count_r, count_nxt;
  cnt_t shift_r, shift_nxt;
  logic drop_r,  drop_nxt;
  logic out_valid_r, out_valid_nxt;
  sample_t median_r;
  logic    empty_r;
  logic    ovf_r;
  cnt_t    n_r;

  logic      acc;
  logic      full;
  logic      take;
  logic      load;
  cnt_t      cnt_ins;
  mos_ctrl_t ctrl;
  sample_t   median_c;
  logic signed [SAMPLE_W:0] sum;

  logic    [MAX_ITEMS-1:0] ins;
  sample_t                 vals [MAX_ITEMS];

  assign in_if.ready = (state_r == ST_FILL);
  assign acc         = in_if.valid && in_if.ready;
  assign full        = (count_r >= cnt_t'(MAX_ITEMS));
  assign take        = acc && in_if.has_sample && !full;
  assign cnt_ins     = count_r + cnt_t'(take);
  assign load        = (state_r == ST_SHIFT) && (shift_r == '0) &&
                       (!out_valid_r || out_if.ready);

  assign ctrl.ins_en   = take;
  assign ctrl.shift_en = (state_r == ST_SHIFT) && (shift_r != '0);
  assign ctrl.sample   = in_if.sample;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic    l_ins;
    sample_t l_val;
    sample_t r_val;
    if (i == 0) begin : g_first
      assign l_ins = 1'b0;
      assign l_val = '0;
    end else begin : g_mid
      assign l_ins = ins[i-1];
      assign l_val = vals[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_end
      assign r_val = '0;
    end else begin : g_inner
      assign r_val = vals[i+1];
    end
    mos_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (cnt_t'(i) < count_r),
      .left_ins  (l_ins),
      .left_val  (l_val),
      .right_val (r_val),
      .ins       (ins[i]),
      .val       (vals[i])
    );
  end

  generate
    if (MAX_ITEMS > 1) begin : g_pair
      assign sum = {vals[0][SAMPLE_W-1], vals[0]} + {vals[1][SAMPLE_W-1], vals[1]};
    end else begin : g_single
      assign sum = {vals[0][SAMPLE_W-1], vals[0]} + {vals[0][SAMPLE_W-1], vals[0]};
    end
  endgenerate

  always_comb begin
    if (count_r == '0) begin
      median_c = '0;
    end else if (count_r[0]) begin
      median_c = vals[0];
    end else begin
      median_c = sum[SAMPLE_W:1];
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    shift_nxt = shift_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      ST_FILL: begin
        count_nxt = cnt_ins;
        drop_nxt  = drop_r || (acc && in_if.has_sample && full);
        if (acc && in_if.last) begin
          state_nxt = ST_SHIFT;
          shift_nxt = (cnt_ins == '0) ? '0 : ((cnt_ins - cnt_t'(1)) >> 1);
        end
      end
      ST_SHIFT: begin
        if (shift_r != '0) begin
          shift_nxt = shift_r - cnt_t'(1);
        end else if (load) begin
          state_nxt = ST_FILL;
          count_nxt = '0;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      count_r     <= '0;
      shift_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      shift_r     <= shift_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      median_r <= median_c;
      empty_r  <= (count_r == '0);
      ovf_r    <= drop_r;
      n_r      <= count_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.median       = median_r;
  assign out_if.empty_set    = empty_r;
  assign out_if.overflowed   = ovf_r;
  assign out_if.sample_count = n_r;

  `MOS_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_r <= cnt_t'(MAX_ITEMS))
  `MOS_ASSERT_IMPL(a_no_take_in_shift, clk, rst_n, state_r == ST_SHIFT, !in_if.ready)
  `MOS_ASSERT_NEXT(a_load_clears, clk, rst_n, load, (count_r == '0) && !drop_r && out_valid_r)
  `MOS_ASSERT_IMPL(a_drop_when_full, clk, rst_n, $rose(drop_r), count_r == cnt_t'(MAX_ITEMS))

endmodule

`default_nettype wire
